// ===== sv/ppdq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the preamble packet deframer with ring queue.
// Used by the receiver and the top level.
package ppdq_pkg;

  localparam int QueueDepth = 64;
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int QOccW      = $clog2(QueueDepth + 1);

  typedef logic [QIdxW-1:0] q_idx_t;
  typedef logic [QOccW-1:0] q_occ_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PREAMBLE_FIRST  = 2'd0,
    CFG_PREAMBLE_SECOND = 2'd1,
    CFG_HEADER_BYTES    = 2'd2
  } cfg_idx_e;

  // Request kinds.
  typedef enum logic {
    REQ_RX  = 1'b0,
    REQ_POP = 1'b1
  } req_type_e;

  // Receiver phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PRE  = 4'b0010,
    PH_SIZE = 4'b0100,
    PH_DATA = 4'b1000
  } rx_phase_e;

  // What the receiver decides for one received byte.
  typedef struct packed {
    logic push;
    logic done;
  } rx_ctl_t;

  function automatic q_idx_t next_slot(input q_idx_t idx);
    return (idx == q_idx_t'(QueueDepth - 1)) ? '0 : idx + q_idx_t'(1);
  endfunction

endpackage

// ===== sv/ppdq_rx_fsm.sv =====
`timescale 1ns / 1ps
// Frame receiver: preamble search, length byte and frame byte countdown.
// Depends on ppdq_pkg for the phase encoding and the control struct.
module ppdq_rx_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        preamble_first_i,
  input  logic [7:0]        preamble_second_i,
  input  logic [7:0]        header_bytes_i,
  output ppdq_pkg::rx_ctl_t ctl_o
);

  ppdq_pkg::rx_phase_e phase_q, phase_d;
  logic [7:0] remaining_q, remaining_d;
  logic [7:0] rem_start;
  logic [7:0] rem_next;

  // The length byte itself is the first byte counted into the frame.
  assign rem_start = (phase_q == ppdq_pkg::PH_SIZE) ? rx_byte_i + header_bytes_i
                                                    : remaining_q;
  assign rem_next  = rem_start - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    ctl_o       = '0;
    unique case (phase_q)
      ppdq_pkg::PH_IDLE: begin
        if (rx_byte_i == preamble_first_i) phase_d = ppdq_pkg::PH_PRE;
      end
      ppdq_pkg::PH_PRE: begin
        phase_d = (rx_byte_i == preamble_second_i) ? ppdq_pkg::PH_SIZE
                                                   : ppdq_pkg::PH_IDLE;
      end
      ppdq_pkg::PH_SIZE, ppdq_pkg::PH_DATA: begin
        ctl_o.push  = 1'b1;
        remaining_d = rem_next;
        if (rem_next == 8'd0) begin
          ctl_o.done = 1'b1;
          phase_d    = ppdq_pkg::PH_IDLE;
        end else begin
          phase_d = ppdq_pkg::PH_DATA;
        end
      end
      default: begin
        phase_d = ppdq_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ppdq_pkg::PH_IDLE;
      remaining_q <= 8'd0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

// ===== sv/preamble_packet_deframer_ring_queue.sv =====
`timescale 1ns / 1ps
// Results are registered out of stage 1. Throughput: one transaction per
// cycle while in_stall_o is low; the byte store's registered read feeds
// a second stage that settles the packet count and pop bookkeeping.
// Reset clears the receiver, queue pointers, occupancy and counters and
// loads the register defaults; the byte store itself is not cleared.
module preamble_packet_deframer_ring_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pop_byte_o,
  output logic       queue_was_empty_o,
  output logic       last_of_packet_o,
  output logic       frame_complete_o,
  output logic       overwrote_oldest_o,
  output logic [7:0] packets_ready_o
);

  // Configuration registers.
  logic [7:0] pre_first_q, pre_second_q, hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_first_q  <= 8'd170;
      pre_second_q <= 8'd85;
      hdr_q        <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppdq_pkg::CFG_PREAMBLE_FIRST:  pre_first_q  <= cfg_data_i;
        ppdq_pkg::CFG_PREAMBLE_SECOND: pre_second_q <= cfg_data_i;
        ppdq_pkg::CFG_HEADER_BYTES:    hdr_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake.
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic out_valid_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 0: receiver and queue pointers.
  logic              rx_en;
  logic              pop_req;
  ppdq_pkg::rx_ctl_t rx_ctl;

  assign rx_en   = in_acc && (req_type_i == ppdq_pkg::REQ_RX);
  assign pop_req = in_acc && (req_type_i == ppdq_pkg::REQ_POP);

  ppdq_rx_fsm u_rx (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (rx_en),
    .rx_byte_i         (rx_byte_i),
    .preamble_first_i  (pre_first_q),
    .preamble_second_i (pre_second_q),
    .header_bytes_i    (hdr_q),
    .ctl_o             (rx_ctl)
  );

  ppdq_pkg::q_idx_t rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  ppdq_pkg::q_occ_t occ_q, occ_d;
  logic             push, full, empty, pop_ok, over;

  assign push   = rx_en && rx_ctl.push;
  assign full   = (occ_q == ppdq_pkg::q_occ_t'(ppdq_pkg::QueueDepth));
  assign empty  = (occ_q == '0);
  assign pop_ok = pop_req && !empty;
  assign over   = push && full;

  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    occ_d    = occ_q;
    if (push) begin
      wr_idx_d = ppdq_pkg::next_slot(wr_idx_q);
      if (full) begin
        rd_idx_d = ppdq_pkg::next_slot(rd_idx_q);
      end else begin
        occ_d = occ_q + ppdq_pkg::q_occ_t'(1);
      end
    end else if (pop_ok) begin
      rd_idx_d = ppdq_pkg::next_slot(rd_idx_q);
      occ_d    = occ_q - ppdq_pkg::q_occ_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      occ_q    <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      occ_q    <= occ_d;
    end
  end

  // Byte store. Only one transaction is taken per cycle, so a write and a
  // read never fall on the same edge and no forwarding is needed.
  logic [7:0] mem_q [ppdq_pkg::QueueDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_idx_q] <= rx_byte_i;
    if (pop_ok) rd_data_q <= mem_q[rd_idx_q];
  end

  // Stage 1 control captured from stage 0.
  logic s1_pop_q, s1_empty_q, s1_done_q, s1_over_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pop_q   <= pop_ok;
      s1_empty_q <= pop_req && empty;
      s1_done_q  <= rx_en && rx_ctl.done;
      s1_over_q  <= over;
    end
  end

  // Stage 1: packet bookkeeping on the byte read back.
  logic [7:0] rd_rem_q, pend_q;
  logic [7:0] pb, rr_start, rr_next, pend_d;
  logic       last;

  assign pb       = s1_pop_q ? rd_data_q : 8'd0;
  assign rr_start = (rd_rem_q == 8'd0) ? pb + hdr_q : rd_rem_q;
  assign rr_next  = rr_start - 8'd1;
  assign last     = s1_pop_q && (rr_next == 8'd0);

  always_comb begin
    pend_d = pend_q;
    if (s1_done_q) begin
      pend_d = pend_q + 8'd1;
    end else if (last) begin
      pend_d = pend_q - 8'd1;
    end
  end

  logic s1_fire;
  assign s1_fire = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_rem_q    <= 8'd0;
      pend_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        pend_q <= pend_d;
        if (s1_pop_q) rd_rem_q <= rr_next;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pop_byte_o         <= pb;
      queue_was_empty_o  <= s1_empty_q;
      last_of_packet_o   <= last;
      frame_complete_o   <= s1_done_q;
      overwrote_oldest_o <= s1_over_q;
      packets_ready_o    <= pend_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/ppdq_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the deframer top level, attached by the bind below.
// Sees the top-level ports only; no package dependency.
module ppdq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] pop_byte_o,
  input logic       queue_was_empty_o,
  input logic       last_of_packet_o,
  input logic       frame_complete_o,
  input logic       overwrote_oldest_o,
  input logic [7:0] packets_ready_o
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packets_ready_o))
    else $error("stalled result dropped or changed");

  // A pop on an empty queue yields a zero byte and ends no packet.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && queue_was_empty_o |-> pop_byte_o == 8'd0 && !last_of_packet_o)
    else $error("empty pop returned data");

  // A frame end comes from a received byte, never from a pop.
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_complete_o |-> !last_of_packet_o && !queue_was_empty_o)
    else $error("frame end flagged on a pop");

  // An overwrite comes from a push only.
  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overwrote_oldest_o |-> !queue_was_empty_o && !last_of_packet_o
      && pop_byte_o == 8'd0)
    else $error("overwrite flagged on a pop");

endmodule

bind preamble_packet_deframer_ring_queue ppdq_checker u_ppdq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .pop_byte_o         (pop_byte_o),
  .queue_was_empty_o  (queue_was_empty_o),
  .last_of_packet_o   (last_of_packet_o),
  .frame_complete_o   (frame_complete_o),
  .overwrote_oldest_o (overwrote_oldest_o),
  .packets_ready_o    (packets_ready_o)
);
